>>> hdl/wbfp_pkg.sv
// ----------------------------------------------------------------------------
// wbfp_pkg
// Shared types, constants and helpers of the beacon frame parser.
// ----------------------------------------------------------------------------
package wbfp_pkg;

  localparam int SSID_BYTES_DEF  = 32;
  localparam int OFFSET_BITS_DEF = 12;

  localparam logic [7:0] MAX_CHANNEL_RST = 8'd14;

  localparam int OFS_DEST_LO  = 4;
  localparam int OFS_DEST_HI  = 9;
  localparam int OFS_SRC_LO   = 10;
  localparam int OFS_SRC_HI   = 15;
  localparam int OFS_CAPAB    = 34;
  localparam int OFS_BODY     = 36;

  localparam logic [7:0] BCAST_BYTE = 8'hff;
  localparam logic [7:0] ELEM_SSID  = 8'd0;
  localparam logic [7:0] ELEM_DS    = 8'd3;

  localparam int TDATA_W = 80;

  localparam logic [1:0] FT_MGMT = 2'd0;
  localparam logic [1:0] FT_CTRL = 2'd1;
  localparam logic [1:0] FT_DATA = 2'd2;

  localparam logic [3:0] ST_FOUND      = 4'd0;
  localparam logic [3:0] ST_SHORT      = 4'd1;
  localparam logic [3:0] ST_OTHER_MGMT = 4'd2;
  localparam logic [3:0] ST_CTRL       = 4'd3;
  localparam logic [3:0] ST_DATA       = 4'd4;
  localparam logic [3:0] ST_NOT_BCAST  = 4'd5;
  localparam logic [3:0] ST_ESS_IBSS   = 4'd6;
  localparam logic [3:0] ST_BAD_CHAN   = 4'd7;
  localparam logic [3:0] ST_UNKNOWN    = 4'd8;

  localparam logic [1:0] NET_NONE  = 2'd0;
  localparam logic [1:0] NET_AP    = 2'd1;
  localparam logic [1:0] NET_ADHOC = 2'd2;

  localparam logic KIND_SUMMARY = 1'b0;
  localparam logic KIND_SSID    = 1'b1;

  typedef enum logic [1:0] {
    PH_ID   = 2'd0,
    PH_LEN  = 2'd1,
    PH_BODY = 2'd2,
    PH_DS   = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    S_RUN  = 2'd0,
    S_EVAL = 2'd1,
    S_READ = 2'd2,
    S_SSID = 2'd3
  } state_t;

  typedef struct packed {
    logic accept;
    logic load_sum;
    logic rd_en;
    logic load_ssid;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic ssid_more;
    logic ssid_last;
  } sts_t;

  function automatic logic [4:0] header_len(input logic [15:0] fc);
    logic [1:0] ftype;
    logic [3:0] sub;
    logic [4:0] len;
    ftype = fc[3:2];
    sub   = fc[7:4];
    len   = 5'd0;
    case (ftype)
      FT_MGMT: len = 5'd24;
      FT_CTRL: begin
        case (sub) inside
          4'd10, 4'd11, 4'd14, 4'd15: len = 5'd16;
          4'd12, 4'd13:               len = 5'd10;
          default:                    len = 5'd0;
        endcase
      end
      FT_DATA: len = (fc[9:8] == 2'b11) ? 5'd30 : 5'd24;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

>>> hdl/wlan_beacon_frame_parser.sv
// ----------------------------------------------------------------------------
// wlan_beacon_frame_parser
// Byte-serial 802.11 frame parser reporting beacon summaries and SSIDs.
//
// channel  dir  tdata / data                 tuser / tlast
// s_*      in   frame_byte[7:0]              tlast = end_of_frame
// m_*      out  status..ssid_byte (80 bits)  tuser = result_kind, tlast = last
// cfg_*    in   max_channel[7:0]             -
//
// One byte per cycle while a frame streams in.
// On the last byte: an evaluation state, which loads the summary request.
// Each SSID request is a registered RAM read, then a load.
// Input stalls from frame end until the last result is loaded.
// rst is synchronous; an output stall holds the sequencer in place.
// ----------------------------------------------------------------------------
module wlan_beacon_frame_parser #(
  parameter int SSID_BYTES  = wbfp_pkg::SSID_BYTES_DEF,
  parameter int OFFSET_BITS = wbfp_pkg::OFFSET_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [7:0]                   s_tdata,   // frame_byte
  input  logic                         s_tlast,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // status[3:0], network[5:4], channel[13:6], privacy[14], ssid count[20:15],
  // hidden_ssid[21], sender_mac[69:22], ssid_byte[77:70], zero[79:78]
  output logic [wbfp_pkg::TDATA_W-1:0] m_tdata,
  output logic                         m_tuser,   // result_kind
  output logic                         m_tlast,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [7:0]                   cfg_data   // max_channel
);

  wbfp_pkg::cmd_t cmd;
  wbfp_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  wbfp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tlast  (s_tlast),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  wbfp_dp #(
    .SSID_BYTES  (SSID_BYTES),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .s_tdata   (s_tdata),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

>>> hdl/wbfp_ram.sv
// ----------------------------------------------------------------------------
// wbfp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wbfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/wbfp_ctrl.sv
// ----------------------------------------------------------------------------
// wbfp_ctrl
// Sequencer: byte intake, summary evaluation and SSID readout.
// ----------------------------------------------------------------------------
module wbfp_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  input  logic           s_tlast,
  output logic           s_tready,
  input  wbfp_pkg::sts_t sts,
  output wbfp_pkg::cmd_t cmd
);

  wbfp_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wbfp_pkg::S_RUN;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      wbfp_pkg::S_RUN: begin
        if (s_tvalid && s_tlast) state_next = wbfp_pkg::S_EVAL;
      end
      wbfp_pkg::S_EVAL: begin
        if (sts.out_free) begin
          state_next = sts.ssid_more ? wbfp_pkg::S_READ : wbfp_pkg::S_RUN;
        end
      end
      wbfp_pkg::S_READ: state_next = wbfp_pkg::S_SSID;
      wbfp_pkg::S_SSID: begin
        if (sts.out_free) begin
          state_next = sts.ssid_last ? wbfp_pkg::S_RUN : wbfp_pkg::S_READ;
        end
      end
      default: state_next = wbfp_pkg::S_RUN;
    endcase
  end

  always_comb begin
    s_tready      = (state == wbfp_pkg::S_RUN);
    cmd.accept    = s_tvalid && (state == wbfp_pkg::S_RUN);
    cmd.load_sum  = (state == wbfp_pkg::S_EVAL) && sts.out_free;
    cmd.rd_en     = (state == wbfp_pkg::S_READ);
    cmd.load_ssid = (state == wbfp_pkg::S_SSID) && sts.out_free;
  end

  a_eof_to_eval: assert property (@(posedge clk) disable iff (rst)
    cmd.accept && s_tlast |=> state == wbfp_pkg::S_EVAL)
    else $error("frame end did not start evaluation");

  a_read_then_emit: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_en |=> state == wbfp_pkg::S_SSID)
    else $error("SSID read not followed by emit state");

endmodule

>>> hdl/wbfp_dp.sv
// ----------------------------------------------------------------------------
// wbfp_dp
// Datapath: header capture, element walk, SSID store and result register.
// ----------------------------------------------------------------------------
module wbfp_dp #(
  parameter int SSID_BYTES  = wbfp_pkg::SSID_BYTES_DEF,
  parameter int OFFSET_BITS = wbfp_pkg::OFFSET_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  wbfp_pkg::cmd_t               cmd,
  output wbfp_pkg::sts_t               sts,
  input  logic [7:0]                   s_tdata,
  input  logic                         cfg_valid,
  input  logic [7:0]                   cfg_data,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [wbfp_pkg::TDATA_W-1:0] m_tdata,
  output logic                         m_tuser,
  output logic                         m_tlast
);

  localparam int AW = (SSID_BYTES > 1) ? $clog2(SSID_BYTES) : 1;
  localparam int LW = $clog2(SSID_BYTES + 1);
  localparam int OB = OFFSET_BITS;

  logic [7:0]            max_channel;
  logic [OB-1:0]         byte_offset;
  logic [15:0]           frame_control;
  logic                  dest_broadcast;
  logic [47:0]           sender_address;
  logic [2:0]            capability_bits;
  logic [7:0]            channel_number;
  logic [7:0]            element_id;
  logic [7:0]            element_remaining;
  wbfp_pkg::phase_t      element_phase;
  logic [LW-1:0]         ssid_length;
  logic                  ssid_first_zero;
  logic [LW-1:0]         emit_total;
  logic [LW-1:0]         rd_idx;

  logic                  beacon;
  logic                  in_body;
  logic [7:0]            rem_dec;
  logic                  ssid_we;
  logic [7:0]            ssid_rdata;
  logic [3:0]            status;
  logic [1:0]            net_kind;
  logic                  found;

  assign beacon  = (frame_control[7:2] == 6'b100000);
  assign in_body = beacon && (byte_offset >= OB'(wbfp_pkg::OFS_BODY));
  assign rem_dec = element_remaining - 8'd1;
  assign ssid_we = cmd.accept && in_body && (element_phase == wbfp_pkg::PH_BODY)
                   && (element_id == wbfp_pkg::ELEM_SSID)
                   && (ssid_length < LW'(SSID_BYTES));

  always_ff @(posedge clk) begin
    if (rst) begin
      max_channel <= wbfp_pkg::MAX_CHANNEL_RST;
    end else if (cfg_valid) begin
      max_channel <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.load_sum) begin
      byte_offset       <= '0;
      frame_control     <= '0;
      dest_broadcast    <= 1'b1;
      sender_address    <= '0;
      capability_bits   <= '0;
      channel_number    <= '0;
      element_id        <= '0;
      element_remaining <= '0;
      element_phase     <= wbfp_pkg::PH_ID;
      ssid_length       <= '0;
      ssid_first_zero   <= 1'b0;
    end else if (cmd.accept) begin
      if (byte_offset != '1) byte_offset <= byte_offset + 1'b1;
      if (byte_offset == OB'(0)) begin
        frame_control[7:0] <= s_tdata;
      end else if (byte_offset == OB'(1)) begin
        frame_control[15:8] <= s_tdata;
      end else if (byte_offset >= OB'(wbfp_pkg::OFS_DEST_LO) &&
                   byte_offset <= OB'(wbfp_pkg::OFS_DEST_HI)) begin
        if (s_tdata != wbfp_pkg::BCAST_BYTE) dest_broadcast <= 1'b0;
      end else if (byte_offset >= OB'(wbfp_pkg::OFS_SRC_LO) &&
                   byte_offset <= OB'(wbfp_pkg::OFS_SRC_HI)) begin
        sender_address <= {sender_address[39:0], s_tdata};
      end else if (byte_offset == OB'(wbfp_pkg::OFS_CAPAB)) begin
        if (beacon) capability_bits <= {s_tdata[4], s_tdata[1:0]};
      end else if (in_body) begin
        case (element_phase)
          wbfp_pkg::PH_ID: begin
            element_id    <= s_tdata;
            element_phase <= wbfp_pkg::PH_LEN;
          end
          wbfp_pkg::PH_LEN: begin
            element_remaining <= s_tdata;
            if (s_tdata == 8'd0) begin
              element_phase <= wbfp_pkg::PH_ID;
            end else if (element_id == wbfp_pkg::ELEM_DS) begin
              element_phase <= wbfp_pkg::PH_DS;
            end else begin
              if (element_id == wbfp_pkg::ELEM_SSID) begin
                ssid_length     <= '0;
                ssid_first_zero <= 1'b0;
              end
              element_phase <= wbfp_pkg::PH_BODY;
            end
          end
          wbfp_pkg::PH_DS: begin
            channel_number    <= s_tdata;
            element_remaining <= rem_dec;
            element_phase     <= (rem_dec == 8'd0) ? wbfp_pkg::PH_ID : wbfp_pkg::PH_BODY;
          end
          default: begin
            if (ssid_we) begin
              if (ssid_length == '0) ssid_first_zero <= (s_tdata == 8'd0);
              ssid_length <= ssid_length + 1'b1;
            end
            element_remaining <= rem_dec;
            if (rem_dec == 8'd0) element_phase <= wbfp_pkg::PH_ID;
          end
        endcase
      end
    end
  end

  // byte_offset is min(length, top) and top exceeds every header length
  always_comb begin
    net_kind = wbfp_pkg::NET_NONE;
    if (byte_offset < OB'(2) || byte_offset < OB'(wbfp_pkg::header_len(frame_control))) begin
      status = wbfp_pkg::ST_SHORT;
    end else begin
      case (frame_control[3:2])
        wbfp_pkg::FT_MGMT: begin
          if (!beacon) begin
            status = wbfp_pkg::ST_OTHER_MGMT;
          end else if (!dest_broadcast) begin
            status = wbfp_pkg::ST_NOT_BCAST;
          end else if (capability_bits[0] == capability_bits[1]) begin
            status = wbfp_pkg::ST_ESS_IBSS;
          end else if (channel_number == 8'd0 || channel_number > max_channel) begin
            status = wbfp_pkg::ST_BAD_CHAN;
          end else begin
            status   = wbfp_pkg::ST_FOUND;
            net_kind = capability_bits[0] ? wbfp_pkg::NET_AP : wbfp_pkg::NET_ADHOC;
          end
        end
        wbfp_pkg::FT_CTRL: status = wbfp_pkg::ST_CTRL;
        wbfp_pkg::FT_DATA: status = wbfp_pkg::ST_DATA;
        default:           status = wbfp_pkg::ST_UNKNOWN;
      endcase
    end
  end

  assign found = (status == wbfp_pkg::ST_FOUND);

  assign sts.out_free  = !m_tvalid || m_tready;
  assign sts.ssid_more = found && (ssid_length != '0);
  assign sts.ssid_last = ((rd_idx + 1'b1) == emit_total);

  always_ff @(posedge clk) begin
    if (rst) begin
      emit_total <= '0;
      rd_idx     <= '0;
    end else if (cmd.load_sum) begin
      emit_total <= found ? ssid_length : '0;
      rd_idx     <= '0;
    end else if (cmd.load_ssid) begin
      rd_idx <= rd_idx + 1'b1;
    end
  end

  wbfp_ram #(
    .WIDTH (8),
    .DEPTH (SSID_BYTES)
  ) u_ssid_ram (
    .clk   (clk),
    .we    (ssid_we),
    .waddr (ssid_length[AW-1:0]),
    .wdata (s_tdata),
    .re    (cmd.rd_en),
    .raddr (rd_idx[AW-1:0]),
    .rdata (ssid_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_sum || cmd.load_ssid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // tdata: status, network, channel, privacy, ssid count, hidden_ssid, sender_mac, ssid_byte
  always_ff @(posedge clk) begin
    if (cmd.load_sum) begin
      m_tuser <= wbfp_pkg::KIND_SUMMARY;
      m_tlast <= !sts.ssid_more;
      if (found) begin
        m_tdata <= {2'b00, 8'd0, sender_address, ssid_first_zero, 6'(ssid_length),
                    capability_bits[2], channel_number, net_kind, status};
      end else begin
        m_tdata <= {76'd0, status};
      end
    end else if (cmd.load_ssid) begin
      m_tuser <= wbfp_pkg::KIND_SSID;
      m_tlast <= sts.ssid_last;
      m_tdata <= {2'b00, ssid_rdata, 70'd0};
    end
  end

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    ssid_length <= LW'(SSID_BYTES))
    else $error("SSID length beyond store");

  a_emit_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.load_ssid |-> rd_idx < emit_total)
    else $error("SSID readout beyond kept bytes");

  a_sum_last: assert property (@(posedge clk) disable iff (rst)
    cmd.load_sum && !sts.ssid_more |=> m_tvalid && m_tlast)
    else $error("lone summary not marked last");

endmodule

>>> tb/tb_wlan_beacon_frame_parser.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_wlan_beacon_frame_parser
// Self-checking bench for the byte-serial 802.11 beacon frame parser.
//
// Frames are built byte by byte (beacons with tagged elements, other frame
// types, short and truncated frames, noise) and streamed in with random
// gaps. A parser model in the bench tracks header, capability bits and the
// element walk, and queues the expected summary and SSID requests per frame.
// Output requests are checked field by field in order under random and
// long output stalls. max_channel is rewritten between phases.
// ----------------------------------------------------------------------------
module tb_wlan_beacon_frame_parser;

  localparam int         STALL_CYCLES = 300;
  localparam logic [7:0] ELEM_RATES   = 8'd1;
  localparam logic [7:0] ELEM_TIM     = 8'd5;
  localparam logic [7:0] CAP_ESS      = 8'h01;
  localparam logic [7:0] CAP_ADHOC    = 8'h02;
  localparam logic [7:0] CAP_PRIV     = 8'h10;
  localparam logic [1:0] FT_RSVD      = 2'd3;

  typedef struct packed {
    logic        kind;
    logic [3:0]  status;
    logic [1:0]  net;
    logic [7:0]  chan;
    logic        priv;
    logic [5:0]  slen;
    logic        hidden;
    logic [47:0] mac;
    logic [7:0]  sbyte;
    logic        last;
  } report_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         s_tvalid = 1'b0;
  logic                         s_tready;
  logic [7:0]                   s_tdata = 8'd0;
  logic                         s_tlast = 1'b0;
  logic                         m_tvalid;
  logic                         m_tready = 1'b0;
  logic [wbfp_pkg::TDATA_W-1:0] m_tdata;
  logic                         m_tuser;
  logic                         m_tlast;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [7:0]                   cfg_data = 8'd0;

  wlan_beacon_frame_parser dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // parser model state
  logic [wbfp_pkg::OFFSET_BITS_DEF-1:0] ofs;
  logic [15:0]       fc;
  logic              dst_bcast;
  logic [47:0]       src_mac;
  logic [2:0]        cap_bits;
  logic [7:0]        ds_chan;
  logic [7:0]        elem_id;
  logic [7:0]        elem_left;
  wbfp_pkg::phase_t  elem_ph;
  logic [7:0]        ssid_mem [wbfp_pkg::SSID_BYTES_DEF];
  logic [5:0]        ssid_cnt;
  logic              ssid_zero;
  logic [7:0]        max_chan = wbfp_pkg::MAX_CHANNEL_RST;

  report_t     beacon_reports[$];
  logic [7:0]  frame_bytes[$];
  int          bytes_sent;
  int          reports_queued;
  int          mismatches;
  int          src_idle;
  int          snk_idle;
  int          stall_reqs;

  function automatic void clear_parse_state();
    ofs       = '0;
    fc        = '0;
    dst_bcast = 1'b1;
    src_mac   = '0;
    cap_bits  = '0;
    ds_chan   = '0;
    elem_id   = '0;
    elem_left = '0;
    elem_ph   = wbfp_pkg::PH_ID;
    ssid_cnt  = '0;
    ssid_zero = 1'b0;
  endfunction

  function automatic logic [4:0] min_header(input logic [15:0] f);
    case (f[3:2])
      wbfp_pkg::FT_MGMT: return 5'd24;
      wbfp_pkg::FT_DATA: return (f[9] & f[8]) ? 5'd30 : 5'd24;
      wbfp_pkg::FT_CTRL: begin
        case (f[7:5])
          3'b101, 3'b111: return 5'd16;
          3'b110:         return 5'd10;
          default:        return 5'd0;
        endcase
      end
      default: return 5'd0;
    endcase
  endfunction

  function automatic void walk_elements(input logic [7:0] b);
    case (elem_ph)
      wbfp_pkg::PH_ID: begin
        elem_id = b;
        elem_ph = wbfp_pkg::PH_LEN;
      end
      wbfp_pkg::PH_LEN: begin
        elem_left = b;
        if (b == 8'd0) begin
          elem_ph = wbfp_pkg::PH_ID;
        end else if (elem_id == wbfp_pkg::ELEM_DS) begin
          elem_ph = wbfp_pkg::PH_DS;
        end else begin
          if (elem_id == wbfp_pkg::ELEM_SSID) begin
            ssid_cnt  = '0;
            ssid_zero = 1'b0;
          end
          elem_ph = wbfp_pkg::PH_BODY;
        end
      end
      wbfp_pkg::PH_DS: begin
        ds_chan   = b;
        elem_left = elem_left - 8'd1;
        elem_ph   = (elem_left == 8'd0) ? wbfp_pkg::PH_ID : wbfp_pkg::PH_BODY;
      end
      default: begin
        if (elem_id == wbfp_pkg::ELEM_SSID && ssid_cnt < wbfp_pkg::SSID_BYTES_DEF) begin
          if (ssid_cnt == 0) ssid_zero = (b == 8'd0);
          ssid_mem[ssid_cnt[4:0]] = b;
          ssid_cnt = ssid_cnt + 6'd1;
        end
        elem_left = elem_left - 8'd1;
        if (elem_left == 8'd0) elem_ph = wbfp_pkg::PH_ID;
      end
    endcase
  endfunction

  // advance the model by one accepted byte; queue the requests of a frame end
  function automatic void parse_byte(input logic [7:0] b, input logic eof);
    logic [wbfp_pkg::OFFSET_BITS_DEF-1:0] idx;
    logic                                 is_bcn;
    int                                   flen;
    int                                   n_ssid;
    logic [3:0]                           st;
    report_t                              r;
    idx    = ofs;
    is_bcn = (fc[7:2] == 6'b100000);
    if (idx == 0) begin
      fc[7:0] = b;
    end else if (idx == 1) begin
      fc[15:8] = b;
    end else if (idx >= wbfp_pkg::OFS_DEST_LO && idx <= wbfp_pkg::OFS_DEST_HI) begin
      if (b != wbfp_pkg::BCAST_BYTE) dst_bcast = 1'b0;
    end else if (idx >= wbfp_pkg::OFS_SRC_LO && idx <= wbfp_pkg::OFS_SRC_HI) begin
      src_mac = {src_mac[39:0], b};
    end else if (idx == wbfp_pkg::OFS_CAPAB) begin
      if (is_bcn) cap_bits = {b[4], b[1:0]};
    end else if (idx >= wbfp_pkg::OFS_BODY) begin
      if (is_bcn) walk_elements(b);
    end
    if (ofs != '1) ofs = ofs + 1'b1;
    if (!eof) return;

    flen = int'(idx) + 1;
    if (flen < 2 || flen < min_header(fc)) begin
      st = wbfp_pkg::ST_SHORT;
    end else begin
      case (fc[3:2])
        wbfp_pkg::FT_MGMT: begin
          if (!is_bcn)                          st = wbfp_pkg::ST_OTHER_MGMT;
          else if (!dst_bcast)                  st = wbfp_pkg::ST_NOT_BCAST;
          else if (cap_bits[0] == cap_bits[1])  st = wbfp_pkg::ST_ESS_IBSS;
          else if (ds_chan == 8'd0 || ds_chan > max_chan) st = wbfp_pkg::ST_BAD_CHAN;
          else                                  st = wbfp_pkg::ST_FOUND;
        end
        wbfp_pkg::FT_CTRL: st = wbfp_pkg::ST_CTRL;
        wbfp_pkg::FT_DATA: st = wbfp_pkg::ST_DATA;
        default:           st = wbfp_pkg::ST_UNKNOWN;
      endcase
    end

    n_ssid   = (st == wbfp_pkg::ST_FOUND) ? int'(ssid_cnt) : 0;
    r        = '0;
    r.kind   = wbfp_pkg::KIND_SUMMARY;
    r.status = st;
    if (st == wbfp_pkg::ST_FOUND) begin
      r.net    = cap_bits[0] ? wbfp_pkg::NET_AP : wbfp_pkg::NET_ADHOC;
      r.chan   = ds_chan;
      r.priv   = cap_bits[2];
      r.slen   = ssid_cnt;
      r.hidden = ssid_zero;
      r.mac    = src_mac;
    end
    r.last = (n_ssid == 0);
    beacon_reports.push_back(r);
    for (int i = 0; i < n_ssid; i++) begin
      r       = '0;
      r.kind  = wbfp_pkg::KIND_SSID;
      r.sbyte = ssid_mem[i];
      r.last  = (i == n_ssid - 1);
      beacon_reports.push_back(r);
    end
    reports_queued += 1 + n_ssid;
    clear_parse_state();
  endfunction

  task automatic flag_mismatch(input string what, input logic [47:0] got,
                               input logic [47:0] want);
    mismatches++;
    $display("error @%0t: %s got %0h expected %0h", $time, what, got, want);
  endtask

  task automatic check_field(input string what, input logic [47:0] got,
                             input logic [47:0] want);
    if (got !== want) flag_mismatch(what, got, want);
  endtask

  always @(posedge clk) begin : result_check
    report_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (beacon_reports.size() == 0) begin
        flag_mismatch("request with none pending", m_tdata[47:0], '0);
      end else begin
        want = beacon_reports.pop_front();
        check_field("result_kind", m_tuser, want.kind);
        check_field("last", m_tlast, want.last);
        check_field("status", m_tdata[3:0], want.status);
        check_field("network", m_tdata[5:4], want.net);
        check_field("channel", m_tdata[13:6], want.chan);
        check_field("privacy", m_tdata[14], want.priv);
        check_field("ssid_count", m_tdata[20:15], want.slen);
        check_field("hidden_ssid", m_tdata[21], want.hidden);
        check_field("sender_mac", m_tdata[69:22], want.mac);
        check_field("ssid_byte", m_tdata[77:70], want.sbyte);
        check_field("pad", m_tdata[79:78], '0);
      end
    end
  end

  // output ready: random stalls, plus a long hold-off on request
  always @(negedge clk) begin : sink_ready
    int stall_left;
    int stall_seen;
    if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else if (stall_seen != stall_reqs) begin
      stall_seen = stall_reqs;
      stall_left = STALL_CYCLES;
      m_tready   <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= snk_idle);
    end
  end

  // entered and left at a falling edge
  task automatic push_byte(input logic [7:0] b, input logic eof);
    while ($urandom_range(99) < src_idle) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= eof;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    parse_byte(b, eof);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_frame();
    int n;
    n = frame_bytes.size();
    for (int i = 0; i < n; i++) push_byte(frame_bytes[i], i == n - 1);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    s_tlast  <= 1'b0;
    while (beacon_reports.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_max_channel(input logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    max_chan = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic void raw_frame(input logic [7:0] fc0, input logic [7:0] fc1,
                                    input int n);
    frame_bytes.delete();
    for (int i = 0; i < n; i++)
      frame_bytes.push_back(i == 0 ? fc0 : i == 1 ? fc1 : 8'($urandom));
  endfunction

  function automatic void make_header(input logic [7:0] fc0, input logic [7:0] fc1,
                                      input logic bc);
    int pos;
    pos = bc ? 6 : $urandom_range(0, 5);
    frame_bytes.delete();
    frame_bytes.push_back(fc0);
    frame_bytes.push_back(fc1);
    repeat (2) frame_bytes.push_back(8'($urandom));
    for (int i = 0; i < 6; i++)
      frame_bytes.push_back(i == pos ? 8'($urandom_range(0, 254)) : wbfp_pkg::BCAST_BYTE);
    repeat (14) frame_bytes.push_back(8'($urandom));
  endfunction

  function automatic void beacon_head(input logic bc, input logic [7:0] cap);
    make_header({6'b100000, 2'($urandom)}, 8'($urandom), bc);
    repeat (10) frame_bytes.push_back(8'($urandom));
    frame_bytes.push_back(cap);
    frame_bytes.push_back(8'($urandom));
  endfunction

  // first < 0: random first body byte (nonzero for an SSID)
  function automatic void add_elem(input logic [7:0] id, input int len,
                                   input int first);
    frame_bytes.push_back(id);
    frame_bytes.push_back(8'(len));
    for (int i = 0; i < len; i++) begin
      if (i == 0 && first >= 0)
        frame_bytes.push_back(8'(first));
      else if (i == 0 && id == wbfp_pkg::ELEM_SSID)
        frame_bytes.push_back(8'($urandom_range(1, 255)));
      else
        frame_bytes.push_back(8'($urandom));
    end
  endfunction

  function automatic void trim_frame(input int n);
    while (frame_bytes.size() > n) void'(frame_bytes.pop_back());
  endfunction

  function automatic int pick_channel();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return max_chan;
      2:       return (max_chan + 1) % 256;
      3:       return 1;
      default: return $urandom_range(1, max_chan);
    endcase
  endfunction

  function automatic void random_beacon();
    logic [7:0] cap;
    int         n_elem;
    cap = 8'($urandom) & 8'hfc;
    case ($urandom_range(0, 9))
      0:       cap |= CAP_ADHOC;
      1:       cap |= CAP_ESS | CAP_ADHOC;
      2:       ;
      3, 4:    cap |= CAP_ADHOC;
      default: cap |= CAP_ESS;
    endcase
    beacon_head($urandom_range(0, 9) != 0, cap);
    if ($urandom_range(0, 19) < 17)
      add_elem(wbfp_pkg::ELEM_SSID, $urandom_range(0, 9) == 0 ? $urandom_range(29, 40)
                                                             : $urandom_range(0, 6),
               $urandom_range(0, 4) == 0 ? 0 : -1);
    n_elem = $urandom_range(0, 3);
    for (int i = 0; i < n_elem; i++) begin
      case ($urandom_range(0, 5))
        0:       add_elem(wbfp_pkg::ELEM_SSID, $urandom_range(0, 5), -1);
        1:       add_elem(wbfp_pkg::ELEM_DS, $urandom_range(1, 2), pick_channel());
        2:       add_elem(ELEM_TIM, $urandom_range(0, 6), -1);
        3:       add_elem(ELEM_RATES, $urandom_range(1, 8), -1);
        default: add_elem(8'($urandom), $urandom_range(0, 5), -1);
      endcase
    end
    if ($urandom_range(0, 4) != 0) add_elem(wbfp_pkg::ELEM_DS, 1, pick_channel());
    if ($urandom_range(0, 9) == 0) trim_frame($urandom_range(1, frame_bytes.size()));
  endfunction

  function automatic void random_frame();
    logic [3:0] sub;
    case ($urandom_range(0, 19))
      12, 13: begin
        sub = 4'($urandom);
        if (sub == 4'd8) sub = 4'd5;
        raw_frame({sub, wbfp_pkg::FT_MGMT, 2'($urandom)}, 8'($urandom),
                  $urandom_range(1, 30));
      end
      14, 15: raw_frame({4'($urandom), wbfp_pkg::FT_CTRL, 2'($urandom)}, 8'($urandom),
                        $urandom_range(1, 20));
      16, 17: raw_frame({4'($urandom), wbfp_pkg::FT_DATA, 2'($urandom)}, 8'($urandom),
                        $urandom_range(1, 34));
      18:     raw_frame({4'($urandom), FT_RSVD, 2'($urandom)}, 8'($urandom),
                        $urandom_range(1, 8));
      19:     raw_frame(8'($urandom), 8'($urandom), $urandom_range(1, 40));
      default: random_beacon();
    endcase
  endfunction

  task automatic test_directed_frames();
    src_idle = 28;
    snk_idle = 49;
    write_max_channel(wbfp_pkg::MAX_CHANNEL_RST);
    raw_frame(8'h80, 8'h00, 1);   send_frame();
    raw_frame(8'hc4, 8'h00, 9);   send_frame();
    raw_frame(8'hc4, 8'h00, 10);  send_frame();
    raw_frame(8'h0c, 8'h00, 2);   send_frame();
    raw_frame(8'h08, 8'h03, 25);  send_frame();
    // ends before the capability byte
    beacon_head(1'b1, CAP_ESS);
    trim_frame(26);
    send_frame();
    // access point with privacy, over-long SSID, empty SSID keeps it,
    // later DS element at the limit wins
    beacon_head(1'b1, 8'hff & ~CAP_ADHOC);
    add_elem(wbfp_pkg::ELEM_SSID, 33, -1);
    add_elem(wbfp_pkg::ELEM_SSID, 0, -1);
    add_elem(wbfp_pkg::ELEM_DS, 1, 2);
    add_elem(ELEM_TIM, 1, -1);
    add_elem(wbfp_pkg::ELEM_DS, 2, wbfp_pkg::MAX_CHANNEL_RST);
    send_frame();
    drain();
  endtask

  task automatic test_random_frames(input int src_pct, input int snk_pct,
                                    input logic [7:0] chan_limit);
    int byte_mark;
    src_idle = src_pct;
    snk_idle = snk_pct;
    write_max_channel(chan_limit);
    byte_mark = bytes_sent;
    while (bytes_sent - byte_mark < 40) begin
      random_frame();
      send_frame();
    end
    drain();
  endtask

  task automatic test_output_hold_off();
    src_idle = 0;
    snk_idle = 0;
    write_max_channel(8'd11);
    stall_reqs++;
    // ad-hoc network with a hidden SSID
    beacon_head(1'b1, CAP_ADHOC);
    add_elem(wbfp_pkg::ELEM_SSID, 4, 0);
    add_elem(wbfp_pkg::ELEM_DS, 1, 11);
    send_frame();
    // channel one above the limit
    beacon_head(1'b1, CAP_ESS | CAP_PRIV);
    add_elem(wbfp_pkg::ELEM_SSID, 4, -1);
    add_elem(wbfp_pkg::ELEM_DS, 1, 12);
    send_frame();
    drain();
  endtask

  initial begin
    clear_parse_state();
    src_idle = 0;
    snk_idle = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed_frames();
    test_random_frames(49, 28, 8'($urandom_range(2, 254)));
    test_output_hold_off();

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
